/* rtl/psd_pkg.sv */
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants for the point-to-segment distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

  // Default coordinate width (signed Q16.16 at 32 bits).
  localparam int COORD_WIDTH_DEF = 32;

  // Dot-product tolerance register.
  localparam int              TOL_W     = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  // Region codes.
  localparam logic [1:0] REGION_INVALID  = 2'd0;
  localparam logic [1:0] REGION_BEGIN    = 2'd1;
  localparam logic [1:0] REGION_END      = 2'd2;
  localparam logic [1:0] REGION_INTERIOR = 2'd3;

endpackage

/* rtl/psd_front.sv */
// ----------------------------------------------------------------------------
// psd_front
// Difference vectors, dot products, region decision and the scaled
// numerator and denominator for the interior projection. Six stages.
// ----------------------------------------------------------------------------
module psd_front #(
  parameter int CW = psd_pkg::COORD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [2:0][CW-1:0]          b_i,
  input  logic [2:0][CW-1:0]          e_i,
  input  logic [2:0][CW-1:0]          q_i,
  input  logic                        ok_i,
  input  logic [psd_pkg::TOL_W-1:0]   tol_i,
  output logic                        out_valid,
  output logic [2:0][3*CW+2:0]        num_o,
  output logic [2*CW+2:0]             den_o,
  // {q, b, cand, vneg, region}
  output logic [9*CW+4:0]             meta_o
);
  import psd_pkg::*;

  localparam int H  = CW + 1;
  localparam int CX = 2*CW + 4;
  localparam int CU = 2*CW + 2;
  localparam int NW = 3*CW + 3;
  localparam int PW = 2*CW + 1;

  // Stage 1: v = e - b, w = q - b.
  logic [5:0] vld_r;
  logic signed [CW:0] v1_r [3];
  logic signed [CW:0] w1_r [3];
  logic [2:0][CW-1:0] b1_r, e1_r, q1_r;
  logic ok1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v1_r[i] <= $signed({e_i[i][CW-1], e_i[i]}) - $signed({b_i[i][CW-1], b_i[i]});
        w1_r[i] <= $signed({q_i[i][CW-1], q_i[i]}) - $signed({b_i[i][CW-1], b_i[i]});
      end
      b1_r  <= b_i;
      e1_r  <= e_i;
      q1_r  <= q_i;
      ok1_r <= ok_i;
    end
  end

  // Stage 2: per-axis products and magnitude of v.
  logic signed [CU-1:0] pw2_r [3];
  logic signed [CU-1:0] pv2_r [3];
  logic [2:0][CW-1:0] b2_r, e2_r, q2_r, vmag2_r;
  logic [2:0] vneg2_r;
  logic ok2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pw2_r[i]   <= CU'(w1_r[i]) * CU'(v1_r[i]);
        pv2_r[i]   <= CU'(v1_r[i]) * CU'(v1_r[i]);
        vneg2_r[i] <= v1_r[i][CW];
        vmag2_r[i] <= v1_r[i][CW] ? CW'(-v1_r[i]) : CW'(v1_r[i]);
      end
      b2_r  <= b1_r;
      e2_r  <= e1_r;
      q2_r  <= q1_r;
      ok2_r <= ok1_r;
    end
  end

  // Stage 3: c1 = w.v and c2 = v.v.
  logic signed [CX-1:0] c1_3_r, c2_3_r;
  logic [2:0][CW-1:0] b3_r, e3_r, q3_r, vmag3_r;
  logic [2:0] vneg3_r;
  logic ok3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c1_3_r  <= CX'(pw2_r[0]) + CX'(pw2_r[1]) + CX'(pw2_r[2]);
      c2_3_r  <= CX'(pv2_r[0]) + CX'(pv2_r[1]) + CX'(pv2_r[2]);
      b3_r    <= b2_r;
      e3_r    <= e2_r;
      q3_r    <= q2_r;
      vmag3_r <= vmag2_r;
      vneg3_r <= vneg2_r;
      ok3_r   <= ok2_r;
    end
  end

  // Stage 4: region decision against the tolerance.
  logic signed [CX-1:0] tolx;
  logic [1:0]           region_nxt;
  assign tolx = $signed({{(CX-TOL_W){1'b0}}, tol_i});

  always_comb begin
    if (!ok3_r) begin
      region_nxt = REGION_INVALID;
    end else if (c1_3_r < tolx) begin
      region_nxt = REGION_BEGIN;
    end else if (c2_3_r < c1_3_r + tolx) begin
      region_nxt = REGION_END;
    end else if (c2_3_r == '0) begin
      region_nxt = REGION_BEGIN;
    end else begin
      region_nxt = REGION_INTERIOR;
    end
  end

  logic [1:0] region4_r;
  logic [2:0][CW-1:0] cand4_r, b4_r, q4_r, vmag4_r;
  logic [2:0] vneg4_r;
  logic [CU-1:0] c1_4_r, c2_4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      region4_r <= region_nxt;
      cand4_r   <= (region_nxt == REGION_END) ? e3_r : b3_r;
      b4_r      <= b3_r;
      q4_r      <= q3_r;
      vmag4_r   <= vmag3_r;
      vneg4_r   <= vneg3_r;
      c1_4_r    <= c1_3_r[CU-1:0];
      c2_4_r    <= c2_3_r[CU-1:0];
    end
  end

  // Stage 5: |v| * c1 as two partial products per axis.
  logic [PW-1:0] plo5_r [3];
  logic [PW-1:0] phi5_r [3];
  logic [CU-1:0] c2_5_r;
  logic [9*CW+4:0] meta5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        plo5_r[i] <= PW'(vmag4_r[i]) * PW'(c1_4_r[H-1:0]);
        phi5_r[i] <= PW'(vmag4_r[i]) * PW'(c1_4_r[CU-1:H]);
      end
      c2_5_r  <= c2_4_r;
      meta5_r <= {q4_r, b4_r, cand4_r, vneg4_r, region4_r};
    end
  end

  // Stage 6: rounding numerator 2*|v|*c1 + c2 and denominator 2*c2.
  logic [2:0][NW-1:0] num6_r;
  logic [CU:0]        den6_r;
  logic [9*CW+4:0]    meta6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num6_r[i] <= ((NW'(plo5_r[i]) + (NW'(phi5_r[i]) << H)) << 1) + NW'(c2_5_r);
      end
      den6_r  <= {c2_5_r, 1'b0};
      meta6_r <= meta5_r;
    end
  end

  assign out_valid = vld_r[5];
  assign num_o     = num6_r;
  assign den_o     = den6_r;
  assign meta_o    = meta6_r;

endmodule

/* rtl/psd_div.sv */
// ----------------------------------------------------------------------------
// psd_div
// Pipelined restoring divider, three lanes sharing one divisor.
// One quotient bit per stage, most significant first.
// ----------------------------------------------------------------------------
module psd_div #(
  parameter int NW = 99,
  parameter int DW = 67,
  parameter int QW = 32,
  parameter int MW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2:0][NW-1:0]  num_i,
  input  logic [DW-1:0]       den_i,
  input  logic [MW-1:0]       meta_i,
  output logic                out_valid,
  output logic [2:0][QW-1:0]  quo_o,
  output logic [MW-1:0]       meta_o
);
  logic [QW-1:0]           vld_r;
  logic [2:0][NW-1:0]      rem_r  [QW];
  logic [2:0][QW-1:0]      quo_r  [QW];
  logic [DW-1:0]           den_r  [QW];
  logic [MW-1:0]           meta_r [QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int SH = QW - 1 - k;
    logic [2:0][NW-1:0] rem_in;
    logic [2:0][QW-1:0] quo_in;
    logic [DW-1:0]      den_in;
    logic [MW-1:0]      meta_in;
    logic [NW-1:0]      trial;

    if (k == 0) begin : g_first
      assign rem_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign meta_in = meta_i;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign den_in  = den_r[k-1];
      assign meta_in = meta_r[k-1];
    end

    assign trial = NW'(den_in) << SH;

    // Subtract the shifted divisor where it fits and record the bit.
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (rem_in[i] >= trial) begin
            rem_r[k][i] <= rem_in[i] - trial;
            quo_r[k][i] <= {quo_in[i][QW-2:0], 1'b1};
          end else begin
            rem_r[k][i] <= rem_in[i];
            quo_r[k][i] <= {quo_in[i][QW-2:0], 1'b0};
          end
        end
        den_r[k]  <= den_in;
        meta_r[k] <= meta_in;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign quo_o     = quo_r[QW-1];
  assign meta_o    = meta_r[QW-1];

endmodule

/* rtl/psd_sqrt.sv */
// ----------------------------------------------------------------------------
// psd_sqrt
// Pipelined integer floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module psd_sqrt #(
  parameter int SW = 66,
  parameter int RW = 33,
  parameter int MW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [SW-1:0]  rad_i,
  input  logic [MW-1:0]  meta_i,
  output logic           out_valid,
  output logic [RW-1:0]  root_o,
  output logic [MW-1:0]  meta_o
);
  localparam int TW = SW + 2;

  logic [RW-1:0] vld_r;
  logic [TW-1:0] rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [MW-1:0] meta_r [RW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[RW-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int BI = RW - 1 - k;
    localparam int SQ = 2 * BI;
    logic [TW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [MW-1:0] meta_in;
    logic [TW-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = TW'(rad_i);
      assign root_in = '0;
      assign meta_in = meta_i;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign meta_in = meta_r[k-1];
    end

    // (r + 2^i)^2 - r^2 = r * 2^(i+1) + 2^(2i)
    assign trial = (TW'(root_in) << (BI + 1)) + ({{(TW-1){1'b0}}, 1'b1} << SQ);

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_r[k]  <= rem_in - trial;
          root_r[k] <= root_in | ({{(RW-1){1'b0}}, 1'b1} << BI);
        end else begin
          rem_r[k]  <= rem_in;
          root_r[k] <= root_in;
        end
        meta_r[k] <= meta_in;
      end
    end
  end

  assign out_valid = vld_r[RW-1];
  assign root_o    = root_r[RW-1];
  assign meta_o    = meta_r[RW-1];

endmodule

/* rtl/point_segment_distance_3d_top.sv */
// ----------------------------------------------------------------------------
// point_segment_distance_3d_top
// Nearest point on a 3D segment to a query point, with floor-sqrt distance.
// ----------------------------------------------------------------------------
// Usage:
// The in_ channel carries one query per transaction: the segment begin and
// end points and the query point in tdata, the two validity flags in tuser.
// The out_ channel returns one result per query, in order: the distance and
// the nearest point in tdata, the region code in tuser. An invalid query
// returns region 0 with all data zero.
// The cfg_ channel writes the dot-product tolerance; it is always ready and
// should only be written while no query is in flight.
// The pipeline is made of six front stages, one divider stage per quotient bit,
// four stages for the nearest point and squared distance, one square-root
// stage per root bit, and the output register. Throughput is one query per
// cycle while the receiver does not stall; the per-bit divider and square-root
// stages set the depth, not the rate.
// Reset clears all valid bits and sets the tolerance to 1.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module point_segment_distance_3d_top #(
  parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // {query_z, query_y, query_x, end_z, end_y, end_x, begin_z, begin_y, begin_x}
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]     in_tdata,
  // {query_ok, segment_ok}
  input  logic [1:0]                             in_tuser,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // {nearest_z, nearest_y, nearest_x, distance}
  output logic [((4*COORD_WIDTH+8)/8)*8-1:0]     out_tdata,
  // {region}
  output logic [1:0]                             out_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  input  logic [psd_pkg::TOL_W-1:0]              cfg_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready
);
  import psd_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int NW  = 3*CW + 3;
  localparam int DW  = 2*CW + 3;
  localparam int MW  = 9*CW + 5;
  localparam int SW  = 2*CW + 2;
  localparam int RW  = CW + 1;
  localparam int ODW = ((4*CW+8)/8)*8;
  localparam int MW2 = 3*CW + 2;

  // Global advance: the pipeline moves when the output register is free.
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Tolerance register.
  logic [TOL_W-1:0] tol_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_valid) begin
      tol_r <= cfg_data;
    end
  end

  // Unpack the input transaction.
  logic [2:0][CW-1:0] b_in, e_in, q_in;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b_in[i] = in_tdata[i*CW +: CW];
      e_in[i] = in_tdata[(3+i)*CW +: CW];
      q_in[i] = in_tdata[(6+i)*CW +: CW];
    end
  end

  // Front end.
  logic                fr_valid;
  logic [2:0][NW-1:0]  fr_num;
  logic [DW-1:0]       fr_den;
  logic [MW-1:0]       fr_meta;

  psd_front #(.CW(CW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .b_i       (b_in),
    .e_i       (e_in),
    .q_i       (q_in),
    .ok_i      (in_tuser[0] & in_tuser[1]),
    .tol_i     (tol_r),
    .out_valid (fr_valid),
    .num_o     (fr_num),
    .den_o     (fr_den),
    .meta_o    (fr_meta)
  );

  // Interior offsets |v| * c1 / c2, rounded.
  logic                dv_valid;
  logic [2:0][CW-1:0]  dv_quo;
  logic [MW-1:0]       dv_meta;

  psd_div #(.NW(NW), .DW(DW), .QW(CW), .MW(MW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .num_i     (fr_num),
    .den_i     (fr_den),
    .meta_i    (fr_meta),
    .out_valid (dv_valid),
    .quo_o     (dv_quo),
    .meta_o    (dv_meta)
  );

  // Meta layout: {q, b, cand, vneg, region}.
  logic [1:0]          dv_region;
  logic [2:0]          dv_vneg;
  logic [2:0][CW-1:0]  dv_cand, dv_b, dv_q;
  assign dv_region = dv_meta[1:0];
  assign dv_vneg   = dv_meta[4:2];
  assign dv_cand   = dv_meta[3*CW+4:5];
  assign dv_b      = dv_meta[6*CW+4:3*CW+5];
  assign dv_q      = dv_meta[9*CW+4:6*CW+5];

  // Post stages: nearest point, |q - n|, squares, squared distance.
  logic [3:0]          pv_r;
  logic [2:0][CW-1:0]  n1_r, q1_r, n2_r, n3_r, n4_r, d2_r;
  logic [1:0]          rg1_r, rg2_r, rg3_r, rg4_r;
  logic [2*CW-1:0]     sq3_r [3];
  logic [SW-1:0]       dsq4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else if (en) begin
      pv_r <= {pv_r[2:0], dv_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_region == REGION_INTERIOR) begin
          n1_r[i] <= dv_vneg[i] ? dv_b[i] - dv_quo[i] : dv_b[i] + dv_quo[i];
        end else begin
          n1_r[i] <= dv_cand[i];
        end
      end
      q1_r  <= dv_q;
      rg1_r <= dv_region;
    end
  end

  logic signed [CW:0] diff [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = $signed({q1_r[i][CW-1], q1_r[i]}) - $signed({n1_r[i][CW-1], n1_r[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d2_r[i] <= diff[i][CW] ? CW'(-diff[i]) : CW'(diff[i]);
        sq3_r[i] <= (2*CW)'(d2_r[i]) * (2*CW)'(d2_r[i]);
      end
      n2_r   <= n1_r;
      rg2_r  <= rg1_r;
      n3_r   <= n2_r;
      rg3_r  <= rg2_r;
      dsq4_r <= SW'(sq3_r[0]) + SW'(sq3_r[1]) + SW'(sq3_r[2]);
      n4_r   <= n3_r;
      rg4_r  <= rg3_r;
    end
  end

  // Floor square root of the squared distance.
  logic            sq_valid;
  logic [RW-1:0]   sq_root;
  logic [MW2-1:0]  sq_meta;

  psd_sqrt #(.SW(SW), .RW(RW), .MW(MW2)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pv_r[3]),
    .rad_i     (dsq4_r),
    .meta_i    ({n4_r, rg4_r}),
    .out_valid (sq_valid),
    .root_o    (sq_root),
    .meta_o    (sq_meta)
  );

  // Output register; invalid queries report zeros.
  logic [ODW-1:0] odata_r;
  logic [1:0]     oreg_r;
  logic           ovld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (en) begin
      ovld_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oreg_r <= sq_meta[1:0];
      if (sq_meta[1:0] == REGION_INVALID) begin
        odata_r <= '0;
      end else begin
        odata_r <= ODW'({sq_meta[MW2-1:2], sq_root});
      end
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = oreg_r;

  // Checks.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == REGION_INVALID |-> out_tdata == '0)
    else $error("invalid query produced nonzero data");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_tol_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_valid |=> $stable(tol_r))
    else $error("tolerance changed without a write");

endmodule
